// ===== design/cossim_pkg.sv =====
// Shared types and constants for the cosine similarity block.
// Used by cossim_ctrl, cossim_dp and cosine_similarity; no dependencies.
package cossim_pkg;

  localparam int ELEM_PORT_W = 16;
  localparam int PROD_W      = 2 * ELEM_PORT_W;
  localparam int SUM_W       = 48;
  localparam int MUL_CHUNK   = 16;
  localparam int MUL_STEPS   = SUM_W / MUL_CHUNK;
  localparam int MUL_IDX_W   = $clog2(MUL_STEPS);
  localparam int MUL_W       = SUM_W + MUL_CHUNK;
  localparam int SQ_W        = 2 * SUM_W;
  localparam int ROOT_W      = SUM_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SIM_W       = 17;

  typedef struct packed {
    logic                 capture;
    logic                 mul_clear;
    logic                 mul_load;
    logic                 mul_add;
    logic [MUL_IDX_W-1:0] mul_idx;
    logic                 sqrt_clear;
    logic                 sqrt_step;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== design/cossim_ctrl.sv =====
// Sequencer for the cosine similarity block: accumulate, multiply, root,
// divide, deliver. Depends on cossim_pkg for the command and status types.
module cossim_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                elem_valid,
  input  logic                last_elem,
  output logic                elem_stall,
  input  cossim_pkg::status_t status,
  output cossim_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int CNT_MAX = (cossim_pkg::SQRT_STEPS > FRAC_BITS) ?
                           cossim_pkg::SQRT_STEPS : FRAC_BITS;
  localparam int CNT_W   = $clog2(CNT_MAX);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    elem_stall = 1'b1;
    unique case (state)
      S_ACC: begin
        elem_stall  = 1'b0;
        cmd.capture = elem_valid;
        if (elem_valid && last_elem) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.sqrt_clear = 1'b1;
        cnt_next       = '0;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_clear = (cnt == '0);
        cmd.div_init  = (cnt == '0);
        cmd.mul_load  = (cnt < CNT_W'(cossim_pkg::MUL_STEPS));
        cmd.mul_add   = (cnt != '0);
        cmd.mul_idx   = cnt[cossim_pkg::MUL_IDX_W-1:0];
        if (cnt == CNT_W'(cossim_pkg::MUL_STEPS)) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CNT_W'(cossim_pkg::SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          cnt_next   = '0;
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT: begin
        cmd.out_load = status.out_free;
        if (status.out_free) begin
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

endmodule

// ===== design/cossim_dp.sv =====
// Datapath for the cosine similarity block: saturating sums, chunked product,
// bit-pair square root, restoring fraction divide and output register.
// Depends on cossim_pkg; driven by cossim_ctrl commands.
module cossim_dp #(
  parameter int ELEM_WIDTH = 16,
  parameter int MAX_LEN    = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0]  elem_a,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0]  elem_b,
  input  cossim_pkg::cmd_t                    cmd,
  output cossim_pkg::status_t                 status,
  output logic                                sim_valid,
  input  logic                                sim_stall,
  output logic [cossim_pkg::SIM_W-1:0]        similarity,
  output logic                                zero_magnitude,
  output logic                                overflowed
);

  localparam int EW   = cossim_pkg::ELEM_PORT_W;
  localparam int PW   = cossim_pkg::PROD_W;
  localparam int SW   = cossim_pkg::SUM_W;
  localparam int RW   = cossim_pkg::ROOT_W;
  localparam int QW   = cossim_pkg::SQ_W;
  localparam int MC   = cossim_pkg::MUL_CHUNK;
  localparam int FW   = FRAC_BITS + 1;
  localparam int PC_W = $clog2(MAX_LEN + 1);
  localparam logic [EW-1:0] EMASK =
    (ELEM_WIDTH >= EW) ? {EW{1'b1}} : EW'((64'd1 << ELEM_WIDTH) - 64'd1);
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  logic [EW-1:0] a_eff, b_eff;
  assign a_eff = elem_a & EMASK;
  assign b_eff = elem_b & EMASK;

  // product stage
  logic          pend;
  logic [PW-1:0] p_ab, p_aa, p_bb;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.capture;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_ab <= PW'(a_eff) * PW'(b_eff);
      p_aa <= PW'(a_eff) * PW'(a_eff);
      p_bb <= PW'(b_eff) * PW'(b_eff);
    end
  end

  // saturating accumulators
  logic [SW-1:0]   sum_ab, sum_aa, sum_bb;
  logic [SW:0]     add_ab, add_aa, add_bb;
  logic [PC_W-1:0] pair_count;
  logic            sat_flag, sat_flag_next;
  logic            len_over;

  assign add_ab   = {1'b0, sum_ab} + (SW+1)'(p_ab);
  assign add_aa   = {1'b0, sum_aa} + (SW+1)'(p_aa);
  assign add_bb   = {1'b0, sum_bb} + (SW+1)'(p_bb);
  assign len_over = (pair_count >= PC_W'(MAX_LEN));

  always_comb begin
    sat_flag_next = sat_flag;
    if (cmd.capture && len_over) begin
      sat_flag_next = 1'b1;
    end
    if (pend && (add_ab[SW] || add_aa[SW] || add_bb[SW])) begin
      sat_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum_ab     <= '0;
      sum_aa     <= '0;
      sum_bb     <= '0;
      pair_count <= '0;
      sat_flag   <= 1'b0;
    end else begin
      sat_flag <= sat_flag_next;
      if (cmd.capture && !len_over) begin
        pair_count <= pair_count + 1'b1;
      end
      if (pend) begin
        sum_ab <= add_ab[SW] ? {SW{1'b1}} : add_ab[SW-1:0];
        sum_aa <= add_aa[SW] ? {SW{1'b1}} : add_aa[SW-1:0];
        sum_bb <= add_bb[SW] ? {SW{1'b1}} : add_bb[SW-1:0];
      end
    end
  end

  // aa * bb, one 16-bit chunk of bb per step; shifted out two bits per root step
  logic [cossim_pkg::MUL_STEPS-1:0][MC-1:0] bb_chunks;
  logic [cossim_pkg::MUL_W-1:0]             mul_q;
  logic [cossim_pkg::MUL_IDX_W-1:0]         mul_idx_q;
  logic [QW-1:0]                            prod;

  assign bb_chunks = sum_bb;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_q     <= cossim_pkg::MUL_W'(sum_aa) * cossim_pkg::MUL_W'(bb_chunks[cmd.mul_idx]);
      mul_idx_q <= cmd.mul_idx;
    end
    if (cmd.mul_clear) begin
      prod <= '0;
    end else if (cmd.mul_add) begin
      prod <= prod + (QW'(mul_q) << (MC * mul_idx_q));
    end else if (cmd.sqrt_step) begin
      prod <= prod << 2;
    end
  end

  // integer square root
  logic [RW-1:0] root;
  logic [RW+1:0] rem;
  logic [RW+3:0] rem_sh, trial, rem_diff;
  logic          sq_ge;

  assign rem_sh   = {rem, prod[QW-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign sq_ge    = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_clear) begin
      root <= '0;
      rem  <= '0;
    end else if (cmd.sqrt_step) begin
      root <= {root[RW-2:0], sq_ge};
      rem  <= sq_ge ? rem_diff[RW+1:0] : rem_sh[RW+1:0];
    end
  end

  // fraction divide sum_ab / root
  logic [SW-1:0]        drem;
  logic [SW:0]          dsh, ddiff;
  logic                 dge;
  logic [FRAC_BITS-1:0] quo;

  assign dsh   = {drem, 1'b0};
  assign ddiff = dsh - {1'b0, root};
  assign dge   = (dsh >= {1'b0, root});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= sum_ab;
    end else if (cmd.div_step) begin
      drem <= dge ? ddiff[SW-1:0] : dsh[SW-1:0];
      quo  <= {quo[FRAC_BITS-2:0], dge};
    end
  end

  // result register
  logic                  zero_mag;
  logic [FW-1:0]         sim_full;
  logic [cossim_pkg::SIM_W+FW-1:0] sim_ext;

  assign zero_mag = (sum_aa == '0) || (sum_bb == '0);
  assign sim_full = zero_mag         ? '0  :
                    (sum_ab >= root) ? ONE : {1'b0, quo};
  assign sim_ext  = {{cossim_pkg::SIM_W{1'b0}}, sim_full};

  assign status.out_free = !sim_valid || !sim_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sim_valid <= 1'b0;
    end else if (cmd.out_load) begin
      sim_valid <= 1'b1;
    end else if (!sim_stall) begin
      sim_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      similarity     <= sim_ext[cossim_pkg::SIM_W-1:0];
      zero_magnitude <= zero_mag;
      overflowed     <= sat_flag;
    end
  end

endmodule

// ===== design/cosine_similarity.sv =====
// Throughput: one element pair per cycle while a vector streams in.
// After the last pair is taken, the sequencer runs a drain step, the chunked multiply,
// 48 root steps, FRAC_BITS divide steps and the output load, which waits while a stalled
// result is held; no pair is taken during that time.
// Reset (rst, synchronous, active high) clears the sums, counts, sequencer and output valid.
module cosine_similarity #(
  parameter int ELEM_WIDTH = 16,
  parameter int MAX_LEN    = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               elem_valid,
  output logic                               elem_stall,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0] elem_a,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0] elem_b,
  input  logic                               last_elem,
  output logic                               sim_valid,
  input  logic                               sim_stall,
  output logic [cossim_pkg::SIM_W-1:0]       similarity,
  output logic                               zero_magnitude,
  output logic                               overflowed
);

  cossim_pkg::cmd_t    cmd;
  cossim_pkg::status_t status;

  cossim_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .elem_valid(elem_valid),
    .last_elem (last_elem),
    .elem_stall(elem_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cossim_dp #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .elem_a        (elem_a),
    .elem_b        (elem_b),
    .cmd           (cmd),
    .status        (status),
    .sim_valid     (sim_valid),
    .sim_stall     (sim_stall),
    .similarity    (similarity),
    .zero_magnitude(zero_magnitude),
    .overflowed    (overflowed)
  );

`ifndef SYNTHESIS
  a_zero_mag_result: assert property (@(posedge clk) disable iff (rst)
    sim_valid && zero_magnitude |-> similarity == '0)
    else $error("zero magnitude result with nonzero similarity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register loaded while a result is stalled");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !cmd.mul_load && !cmd.sqrt_step && !cmd.div_step)
    else $error("request taken while the final computation runs");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> sim_valid)
    else $error("result load did not raise valid");
`endif

endmodule

// ===== test/cossim_checker.sv =====
// Checker for cosine_similarity: watches both channels, predicts each result from the
// element requests it sees and compares field by field. Depends on cossim_pkg.
`timescale 1ns / 1ps

module cossim_checker #(
  parameter int ELEM_WIDTH = 16,
  parameter int MAX_LEN    = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               elem_valid,
  input  logic                               elem_stall,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0] elem_a,
  input  logic [cossim_pkg::ELEM_PORT_W-1:0] elem_b,
  input  logic                               last_elem,
  input  logic                               sim_valid,
  input  logic                               sim_stall,
  input  logic [cossim_pkg::SIM_W-1:0]       similarity,
  input  logic                               zero_magnitude,
  input  logic                               overflowed,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_checked,
  output int                                 zero_mag_seen,
  output int                                 overflow_seen
);

  localparam int ELEM_PORT_W = cossim_pkg::ELEM_PORT_W;
  localparam int SUM_W       = cossim_pkg::SUM_W;
  localparam int SIM_W       = cossim_pkg::SIM_W;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [63:0]      ELEM_MASK = (64'd1 << ELEM_WIDTH) - 64'd1;

  typedef struct packed {
    logic [SIM_W-1:0] sim;
    logic             zero_mag;
    logic             ovf;
  } cos_result_t;

  logic [SUM_W-1:0] dot_ab, mag_aa, mag_bb;
  int unsigned      pairs_in_vec;
  logic             sticky_ovf;
  cos_result_t      expected_sims[$];
  cos_result_t      want;
  logic             bad;
  int               fails, seen, zeros, ovfs;

  function automatic logic [63:0] floor_root96(input logic [95:0] v);
    logic [63:0] root, rem, trial;
    root = '0;
    rem  = '0;
    for (int k = 47; k >= 0; k--) begin
      rem   = (rem << 2) | {62'd0, v[2*k +: 2]};
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // floor(num * 2^FRAC_BITS / den), num < den
  function automatic logic [63:0] frac_quotient(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q   = '0;
    rem = num;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      rem = rem << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [SUM_W-1:0] clip_sum(input logic [SUM_W:0] s);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  task automatic accumulate_pair(input logic [ELEM_PORT_W-1:0] a_in,
                                 input logic [ELEM_PORT_W-1:0] b_in, input logic last);
    logic [63:0]    a, b, root, sim;
    logic [SUM_W:0] s_ab, s_aa, s_bb;
    logic [95:0]    prod;
    cos_result_t    r;
    a = {48'd0, a_in} & ELEM_MASK;
    b = {48'd0, b_in} & ELEM_MASK;
    if (pairs_in_vec >= MAX_LEN) sticky_ovf = 1'b1;
    else pairs_in_vec++;
    s_ab = {1'b0, dot_ab};
    s_aa = {1'b0, mag_aa};
    s_bb = {1'b0, mag_bb};
    s_ab = s_ab + (SUM_W+1)'(a * b);
    s_aa = s_aa + (SUM_W+1)'(a * a);
    s_bb = s_bb + (SUM_W+1)'(b * b);
    sticky_ovf = sticky_ovf | s_ab[SUM_W] | s_aa[SUM_W] | s_bb[SUM_W];
    dot_ab = clip_sum(s_ab);
    mag_aa = clip_sum(s_aa);
    mag_bb = clip_sum(s_bb);
    if (!last) return;
    if (mag_aa == '0 || mag_bb == '0) begin
      r.zero_mag = 1'b1;
      sim        = '0;
    end else begin
      r.zero_mag = 1'b0;
      prod       = {48'd0, mag_aa} * {48'd0, mag_bb};
      root       = floor_root96(prod);
      if ({16'd0, dot_ab} >= root) sim = 64'd1 << FRAC_BITS;
      else sim = frac_quotient({16'd0, dot_ab}, root);
    end
    r.sim = sim[SIM_W-1:0];
    r.ovf = sticky_ovf;
    expected_sims.push_back(r);
    dot_ab       = '0;
    mag_aa       = '0;
    mag_bb       = '0;
    pairs_in_vec = 0;
    sticky_ovf   = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dot_ab       = '0;
      mag_aa       = '0;
      mag_bb       = '0;
      pairs_in_vec = 0;
      sticky_ovf   = 1'b0;
      expected_sims.delete();
    end else begin
      if (sim_valid && !sim_stall) begin
        seen++;
        if (zero_magnitude) zeros++;
        if (overflowed) ovfs++;
        if (expected_sims.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result: similarity %0d zero_magnitude %0b overflowed %0b",
                     $realtime, similarity, zero_magnitude, overflowed);
        end else begin
          want = expected_sims.pop_front();
          bad  = 1'b0;
          if (similarity !== want.sim) bad = 1'b1;
          if (zero_magnitude !== want.zero_mag) bad = 1'b1;
          if (overflowed !== want.ovf) bad = 1'b1;
          if (bad) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: result %0d mismatch: similarity exp %0d got %0d, ",
                        "zero_magnitude exp %0b got %0b, overflowed exp %0b got %0b"},
                       $realtime, seen, want.sim, similarity, want.zero_mag, zero_magnitude,
                       want.ovf, overflowed);
          end
        end
      end
      if (elem_valid && !elem_stall) accumulate_pair(elem_a, elem_b, last_elem);
    end
    fail_count      <= fails;
    pending         <= expected_sims.size();
    results_checked <= seen;
    zero_mag_seen   <= zeros;
    overflow_seen   <= ovfs;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the cosine_similarity testbench: clock, reset, element requests, result stall
// and the verdict. Depends on cossim_pkg, cosine_similarity and cossim_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int ELEM_PORT_W  = cossim_pkg::ELEM_PORT_W;
  localparam int SIM_W        = cossim_pkg::SIM_W;
  localparam int ELEM_WIDTH   = 16;
  localparam int MAX_LEN      = 65536;
  localparam int FRAC_BITS    = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = FRAC_BITS + 60;
  localparam int PHASE_PAIRS  = 225;

  typedef enum {FILL_RANDOM, FILL_SMALL, FILL_SPARSE, FILL_EQUAL, FILL_SCALED, FILL_EXTREME}
    fill_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   elem_valid = 1'b0;
  logic                   elem_stall;
  logic [ELEM_PORT_W-1:0] elem_a     = '0;
  logic [ELEM_PORT_W-1:0] elem_b     = '0;
  logic                   last_elem  = 1'b0;
  logic                   sim_valid;
  logic                   sim_stall  = 1'b0;
  logic [SIM_W-1:0]       similarity;
  logic                   zero_magnitude;
  logic                   overflowed;

  int fail_count, pending, results_checked, zero_mag_seen, overflow_seen;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int pairs_sent = 0;
  int quiet      = 0;

  always #2 clk = ~clk;

  cosine_similarity #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .elem_valid    (elem_valid),
    .elem_stall    (elem_stall),
    .elem_a        (elem_a),
    .elem_b        (elem_b),
    .last_elem     (last_elem),
    .sim_valid     (sim_valid),
    .sim_stall     (sim_stall),
    .similarity    (similarity),
    .zero_magnitude(zero_magnitude),
    .overflowed    (overflowed)
  );

  cossim_checker #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) cos_check (
    .clk            (clk),
    .rst            (rst),
    .elem_valid     (elem_valid),
    .elem_stall     (elem_stall),
    .elem_a         (elem_a),
    .elem_b         (elem_b),
    .last_elem      (last_elem),
    .sim_valid      (sim_valid),
    .sim_stall      (sim_stall),
    .similarity     (similarity),
    .zero_magnitude (zero_magnitude),
    .overflowed     (overflowed),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .zero_mag_seen  (zero_mag_seen),
    .overflow_seen  (overflow_seen)
  );

  always @(posedge clk) sim_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (elem_valid && !elem_stall) || (sim_valid && !sim_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_pair(input logic [ELEM_PORT_W-1:0] a, input logic [ELEM_PORT_W-1:0] b,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      elem_valid <= 1'b0;
      @(posedge clk);
    end
    elem_valid <= 1'b1;
    elem_a     <= a;
    elem_b     <= b;
    last_elem  <= last;
    do @(posedge clk); while (elem_stall);
    pairs_sent++;
  endtask

  // hold off requests until every predicted result has been taken
  task automatic settle();
    elem_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_vector(input int len, input fill_t fill);
    logic [ELEM_PORT_W-1:0] a, b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_SMALL: begin
          a = 16'($urandom_range(15));
          b = 16'($urandom_range(15));
        end
        FILL_SPARSE: begin
          a = ($urandom_range(3) == 0) ? 16'($urandom) : '0;
          b = ($urandom_range(3) == 0) ? 16'($urandom) : '0;
        end
        FILL_EQUAL: begin
          a = 16'($urandom);
          b = a;
        end
        FILL_SCALED: begin
          a = 16'($urandom_range(4095));
          b = a << $urandom_range(4);
        end
        FILL_EXTREME: begin
          a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        default: begin
          a = 16'($urandom);
          b = 16'($urandom);
        end
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic random_phase(input int idle, input int stall);
    int start, len;
    idle_pct  = idle;
    stall_pct = stall;
    start     = pairs_sent;
    while (pairs_sent - start < PHASE_PAIRS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      send_vector(len, fill_t'($urandom_range(FILL_EXTREME)));
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'h0000, 16'd1234, 1'b1);
    send_pair(16'd4321, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'd1, 16'd0, 1'b0);
    send_pair(16'd0, 16'd1, 1'b1);
    send_pair(16'hFFFF, 16'd1, 1'b0);
    send_pair(16'd1, 16'hFFFF, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'd3, 16'd4, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1);
    send_pair(16'd1, 16'd2, 1'b0);
    send_pair(16'd2, 16'd4, 1'b0);
    send_pair(16'd3, 16'd6, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'd1, 16'd1, 1'b1);
    settle();

    random_phase(0, 0);
    random_phase(87, 0);
    random_phase(0, 87);
    random_phase(35, 35);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d element pairs as %0d vectors, with idle and stall phases on both sides.",
             pairs_sent, results_checked);
    $display("%0d results had zero magnitude and %0d were flagged as overflowed.",
             zero_mag_seen, overflow_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cossim_pkg.sv
design/cossim_ctrl.sv
design/cossim_dp.sv
design/cosine_similarity.sv
test/cossim_checker.sv
test/testbench.sv
